// ----- sv/rmr_pkg.sv -----
package rmr_pkg;

	// Default operand width of the input fractions.
	localparam int OPERAND_WIDTH_DEF = 16;
	// Width of each result field.
	localparam int OUT_W = 32;
	// Working width for sign restoration of a quotient (covers twice the widest operand).
	localparam int WIDE_W = 64;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_INIT,
		ST_GCD_TEST,
		ST_GCD_WAIT,
		ST_NUM_START,
		ST_NUM_WAIT,
		ST_DEN_START,
		ST_DEN_WAIT,
		ST_OUT
	} rmr_state_t;

	// Operand selection for the shared divider.
	typedef enum logic [1:0] {
		SEL_GCD,
		SEL_NUM,
		SEL_DEN
	} rmr_div_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         load_in;
		logic         mul_en;
		logic         init_gcd;
		logic         div_start;
		rmr_div_sel_t div_sel;
		logic         gcd_step;
		logic         num_save;
		logic         den_save;
		logic         out_load;
	} rmr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic div_done;
		logic out_free;
	} rmr_sts_t;

endpackage

// ----- sv/rmr_divider.sv -----
module rmr_divider #(
	parameter int DATA_W = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient,
	output logic [DATA_W-1:0] remainder
);

	localparam int CNT_W = (DATA_W > 1) ? $clog2(DATA_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		shifted = {rem_q, quo_q[DATA_W-1]};
		diff    = shifted - {1'b0, div_q};
		fits    = ~diff[DATA_W];
	end

	// Sequencing of the shift and subtract steps, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- sv/rmr_datapath.sv -----
module rmr_datapath #(
	parameter int OPERAND_WIDTH = rmr_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rmr_pkg::rmr_cmd_t                       cmd,
	output rmr_pkg::rmr_sts_t                       sts,
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]    in_data,
	input  logic                                    m_tready,
	output logic                                    m_tvalid,
	output logic [2*rmr_pkg::OUT_W-1:0]             m_tdata,
	output logic                                    m_tuser
);

	import rmr_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int MW = 2 * OPERAND_WIDTH - 1;

	logic signed [W-1:0]  na_q, da_q, nb_q, db_q;
	logic signed [PW-1:0] pn_q, pd_q;
	logic [MW-1:0]        x_q, y_q;
	logic [OUT_W-1:0]     qn_q, qd_q;
	logic                 m_tvalid_q;
	logic [2*OUT_W-1:0]   m_tdata_q;
	logic                 m_tuser_q;

	logic [PW-1:0]        neg_n, neg_d;
	logic [MW-1:0]        mag_n, mag_d;
	logic [MW-1:0]        div_dividend, div_divisor;
	logic                 div_done;
	logic [MW-1:0]        div_quo, div_rem;
	logic                 q_sign;
	logic [WIDE_W-1:0]    q_wide, q_neg;
	logic [OUT_W-1:0]     q_signed;
	logic                 err;

	// Magnitudes of the two products.
	always_comb begin
		neg_n = PW'(0) - pn_q;
		neg_d = PW'(0) - pd_q;
		mag_n = pn_q[PW-1] ? neg_n[MW-1:0] : pn_q[MW-1:0];
		mag_d = pd_q[PW-1] ? neg_d[MW-1:0] : pd_q[MW-1:0];
	end

	// Divider operand selection: a Euclid remainder or a reduction by the divisor.
	always_comb begin
		case (cmd.div_sel)
			SEL_GCD: begin
				div_dividend = x_q;
				div_divisor  = y_q;
			end
			SEL_NUM: begin
				div_dividend = mag_n;
				div_divisor  = x_q;
			end
			SEL_DEN: begin
				div_dividend = mag_d;
				div_divisor  = x_q;
			end
			default: begin
				div_dividend = x_q;
				div_divisor  = y_q;
			end
		endcase
	end

	rmr_divider #(
		.DATA_W (MW)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Restore the sign of a quotient and wrap it to the result width.
	always_comb begin
		q_sign   = cmd.num_save ? pn_q[PW-1] : pd_q[PW-1];
		q_wide   = {(WIDE_W-MW)'(0), div_quo};
		q_neg    = WIDE_W'(0) - q_wide;
		q_signed = q_sign ? q_neg[OUT_W-1:0] : q_wide[OUT_W-1:0];
		err      = (x_q == '0);
	end

	// Operand, product, Euclid and quotient registers.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			na_q <= in_data[W-1:0];
			da_q <= in_data[2*W-1:W];
			nb_q <= in_data[3*W-1:2*W];
			db_q <= in_data[4*W-1:3*W];
		end
		if (cmd.mul_en) begin
			pn_q <= PW'(na_q) * PW'(nb_q);
			pd_q <= PW'(da_q) * PW'(db_q);
		end
		if (cmd.init_gcd) begin
			x_q <= mag_n;
			y_q <= mag_d;
		end else if (cmd.gcd_step) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
		if (cmd.num_save) begin
			qn_q <= q_signed;
		end
		if (cmd.den_save) begin
			qd_q <= q_signed;
		end
		if (cmd.out_load) begin
			m_tdata_q <= err ? '0 : {qd_q, qn_q};
			m_tuser_q <= err;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign sts.x_zero   = (x_q == '0);
	assign sts.y_zero   = (y_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_free = ~m_tvalid_q | m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// An error result carries zero numerator and denominator.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error result with nonzero data");

	// A zero denominator without error reduces the numerator to plus or minus one.
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser && (m_tdata[2*OUT_W-1:OUT_W] == '0)) |->
		((m_tdata[OUT_W-1:0] == OUT_W'(1)) || (m_tdata[OUT_W-1:0] == '1)))
		else $error("zero denominator with unreduced numerator");

	// The output register is never overwritten while a result waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register loaded while occupied");

endmodule

// ----- sv/rmr_ctrl.sv -----
module rmr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rmr_pkg::rmr_sts_t sts,
	output rmr_pkg::rmr_cmd_t cmd
);

	import rmr_pkg::*;

	rmr_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				cmd.init_gcd = 1'b1;
				state_d      = ST_GCD_TEST;
			end
			ST_GCD_TEST: begin
				if (!sts.y_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = SEL_GCD;
					state_d       = ST_GCD_WAIT;
				end else if (sts.x_zero) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_NUM_START;
				end
			end
			ST_GCD_WAIT: begin
				cmd.div_sel = SEL_GCD;
				if (sts.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = ST_GCD_TEST;
				end
			end
			ST_NUM_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_NUM;
				state_d       = ST_NUM_WAIT;
			end
			ST_NUM_WAIT: begin
				cmd.div_sel = SEL_NUM;
				if (sts.div_done) begin
					cmd.num_save = 1'b1;
					state_d      = ST_DEN_START;
				end
			end
			ST_DEN_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_DEN;
				state_d       = ST_DEN_WAIT;
			end
			ST_DEN_WAIT: begin
				cmd.div_sel = SEL_DEN;
				if (sts.div_done) begin
					cmd.den_save = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/rational_multiply_reduce.sv -----
// Multiplies two signed fractions a/b and c/d and reduces the product by the
// greatest common divisor of its numerator and denominator products.
// Input channel s_*: one transaction carries num_a, den_a, num_b, den_b.
// Output channel m_*: one transaction per input with num_out, den_out and the
// zero_div_error flag (set, with 0/0, when both products are zero).
// Signs are not normalized; a zero denominator product gives +1/0 or -1/0.
// From acceptance, an item passes through the product multiply, the Euclid
// remainder steps, the numerator and denominator reductions and the output
// register. All divisions run on one shared restoring divider that produces
// one quotient bit per cycle, so it sets the throughput: one item at a time.
// The next item is accepted as soon as the previous result sits in the output
// register, even if the receiver has not taken it yet; a stalled receiver
// then holds the block before its final output stage.
// Reset clears the controller and the output valid flag; no item is lost or
// repeated across a stall.
module rational_multiply_reduce #(
	parameter int OPERAND_WIDTH = rmr_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// num_a, den_a, num_b, den_b from the lowest bits up, zero padded to bytes
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// num_out, den_out from the lowest bits up
	output logic [2*rmr_pkg::OUT_W-1:0]          m_tdata,
	// zero_div_error
	output logic                                 m_tuser
);

	import rmr_pkg::*;

	rmr_cmd_t cmd;
	rmr_sts_t sts;

	rmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmr_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
